>>> src/flv_tag_stream_parser_core_defines.svh
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_core_defines.svh
// Assertion macros used by the FLV tag stream parser back end (flv_tsp_parse).
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_STREAM_PARSER_CORE_DEFINES_SVH
`define FLV_TAG_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FLV_TSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define FLV_TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> src/flv_tsp_pkg.sv
// ----------------------------------------------------------------------------
// flv_tsp_pkg
// Types shared between the front stage, the beat queue and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package flv_tsp_pkg;

  // one stream byte plus the flags the front stage derives from it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       type_ok;   // 0x08, 0x09 or 0x12
    logic       nonzero;
  } flv_beat_t;

endpackage

`default_nettype wire

>>> src/flv_tag_stream_parser_core.sv
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_core
// FLV byte stream parser: file header check, tag header decode, trailer check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one stream byte per beat, in_last_byte
//   on the final byte. Output channel (out_valid/out_ready): one result per
//   completed tag, per error, and at the end of the stream.
//   cfg_wr_en/cfg_wr_data set check_file_header (reset 1); write it only
//   while the block is idle.
//   Path: the byte that causes a result passes the input register, the queue
//   and the parser/result register before the result appears.
//   Throughput: one byte per cycle unless stalled; the parser handles one
//   queued byte per cycle whenever the result register is free or being drained.
//   Stall: when out_ready is low with a result pending, the parser holds, the
//   queue fills and in_ready drops; no result or byte is lost.
//   Reset: rst_n low puts the parser in the file header phase, empties the
//   queue and sets check_file_header. The last byte of a stream also returns
//   the parser to the file header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tag_stream_parser_core
  import flv_tsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_tag_type,
  output logic [23:0]      out_payload_size,
  output logic [31:0]      out_timestamp,
  output logic [2:0]       out_status,
  output logic             out_stream_done
);

  logic      push_valid;
  logic      push_ready;
  flv_beat_t push_beat;
  logic      q_valid;
  logic      q_ready;
  flv_beat_t q_beat;

  flv_tsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_beat    (push_beat)
  );

  flv_tsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_beat  (push_beat),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_beat   (q_beat)
  );

  flv_tsp_parse u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_beat           (q_beat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tag_type     (out_tag_type),
    .out_payload_size (out_payload_size),
    .out_timestamp    (out_timestamp),
    .out_status       (out_status),
    .out_stream_done  (out_stream_done)
  );

endmodule

`default_nettype wire

>>> src/flv_tsp_front.sv
// ----------------------------------------------------------------------------
// flv_tsp_front
// Input register: takes a beat, classifies the byte and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tsp_front
  import flv_tsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            push_valid,
  input  wire logic       push_ready,
  output flv_beat_t       push_beat
);

  localparam logic [7:0] TYPE_AUDIO  = 8'h08;
  localparam logic [7:0] TYPE_VIDEO  = 8'h09;
  localparam logic [7:0] TYPE_SCRIPT = 8'h12;

  logic      valid_r;
  logic      valid_nxt;
  flv_beat_t beat_r;
  logic      take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r.data    <= in_data_byte;
      beat_r.last    <= in_last_byte;
      beat_r.type_ok <= in_data_byte inside {TYPE_AUDIO, TYPE_VIDEO, TYPE_SCRIPT};
      beat_r.nonzero <= (in_data_byte != 8'h00);
    end
  end

endmodule

`default_nettype wire

>>> src/flv_tsp_queue.sv
// ----------------------------------------------------------------------------
// flv_tsp_queue
// Short beat queue between the front stage and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tsp_queue
  import flv_tsp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire flv_beat_t push_beat,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output flv_beat_t      pop_beat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flv_beat_t         ram_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_beat   = ram_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ram_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

`default_nettype wire

>>> src/flv_tsp_parse.sv
// ----------------------------------------------------------------------------
// flv_tsp_parse
// Parser back end: walks file header, tag header, payload and trailer one
// byte per cycle unless a pending result stalls it, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flv_tag_stream_parser_core_defines.svh"

module flv_tsp_parse
  import flv_tsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire flv_beat_t   q_beat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_tag_type,
  output logic [23:0]      out_payload_size,
  output logic [31:0]      out_timestamp,
  output logic [2:0]       out_status,
  output logic             out_stream_done
);

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_TAGHDR,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_ERROR
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_STREAM_ID = 3'd3;
  localparam logic [2:0] ST_SIZE_MISM = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  localparam logic [23:0] FILE_HDR_LEN = 24'd13;
  localparam logic [23:0] TAG_HDR_LEN  = 24'd11;
  localparam logic [23:0] TRAILER_LEN  = 24'd4;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h46;
      4'd1:    v = 8'h4C;
      4'd2:    v = 8'h56;
      4'd3:    v = 8'h01;
      4'd4:    v = 8'h05;
      4'd8:    v = 8'h09;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] time_r, time_nxt;
  logic        nz_r, nz_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        chk_hdr_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_type_r;
  logic [23:0] out_size_r;
  logic [31:0] out_time_r;
  logic [2:0]  out_status_r;
  logic        out_done_r;

  logic        fire;
  logic        emit;
  logic [2:0]  res_status;
  logic        res_done;
  logic [7:0]  res_type;
  logic [23:0] res_size;
  logic [31:0] res_time;
  logic [23:0] cnt_inc;
  logic [24:0] trailer_want;
  logic        have_err;
  logic        tag_end;
  logic [7:0]  b;

  assign q_ready          = !out_valid_r || out_ready;
  assign fire             = q_valid && q_ready;
  assign b                = q_beat.data;
  assign cnt_inc          = cnt_r + 24'd1;
  assign trailer_want     = {1'b0, size_r} + {1'b0, TAG_HDR_LEN};

  assign out_valid        = out_valid_r;
  assign out_tag_type     = out_type_r;
  assign out_payload_size = out_size_r;
  assign out_timestamp    = out_time_r;
  assign out_status       = out_status_r;
  assign out_stream_done  = out_done_r;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    size_nxt   = size_r;
    time_nxt   = time_r;
    nz_nxt     = nz_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    have_err   = 1'b0;
    tag_end    = 1'b0;
    emit       = 1'b0;
    res_status = ST_OK;
    res_done   = 1'b0;

    case (phase_r)
      PH_FILEHDR: begin
        if (chk_hdr_r && (b != magic_byte(cnt_r[3:0]))) begin
          have_err   = 1'b1;
          res_status = ST_BAD_HDR;
        end else if (cnt_inc >= FILE_HDR_LEN) begin
          phase_nxt = PH_TAGHDR;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_TAGHDR: begin
        if (cnt_r == 24'd0) begin
          type_nxt = b;
          if (!q_beat.type_ok) begin
            have_err   = 1'b1;
            res_status = ST_BAD_TYPE;
          end
        end else if (cnt_r <= 24'd3) begin
          size_nxt = {size_r[15:0], b};
        end else if (cnt_r <= 24'd6) begin
          time_nxt = {8'h00, time_r[15:0], b};
        end else if (cnt_r == 24'd7) begin
          time_nxt = {b, time_r[23:0]};
        end else if (q_beat.nonzero) begin
          nz_nxt = 1'b1;
        end
        if (!have_err) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= TAG_HDR_LEN) begin
            if (nz_nxt) begin
              have_err   = 1'b1;
              res_status = ST_STREAM_ID;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = (size_nxt == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= size_r) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        acc_nxt = {acc_r[23:0], b};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= TRAILER_LEN) begin
          tag_end    = 1'b1;
          res_status = (acc_nxt == {7'd0, trailer_want}) ? ST_OK : ST_SIZE_MISM;
          if (res_status != ST_OK) begin
            err_nxt   = res_status;
            phase_nxt = PH_ERROR;
          end else begin
            phase_nxt = PH_TAGHDR;
            cnt_nxt   = '0;
          end
        end
      end
      default: begin
      end
    endcase

    // result fields reflect the tag as seen up to and including this byte
    res_type = type_nxt;
    res_size = size_nxt;
    res_time = time_nxt;

    if (tag_end) begin
      emit     = 1'b1;
      res_done = q_beat.last;
    end else if (have_err) begin
      err_nxt   = res_status;
      phase_nxt = PH_ERROR;
      emit      = 1'b1;
      res_done  = q_beat.last;
    end else if (q_beat.last) begin
      emit     = 1'b1;
      res_done = 1'b1;
      if (phase_nxt == PH_ERROR) begin
        res_status = err_r;
      end else if ((phase_nxt == PH_TAGHDR) && (cnt_nxt == 24'd0)) begin
        res_status = ST_OK;
      end else begin
        res_status = ST_TRUNC;
      end
    end

    // a tag that finished cleanly starts a fresh tag context
    if (tag_end && (res_status == ST_OK)) begin
      type_nxt = '0;
      size_nxt = '0;
      time_nxt = '0;
      nz_nxt   = 1'b0;
      acc_nxt  = '0;
    end
    if ((phase_r == PH_FILEHDR) && (phase_nxt == PH_TAGHDR)) begin
      type_nxt = '0;
      size_nxt = '0;
      time_nxt = '0;
      nz_nxt   = 1'b0;
      acc_nxt  = '0;
    end

    // end of stream: back to the reset context
    if (q_beat.last) begin
      phase_nxt = PH_FILEHDR;
      cnt_nxt   = '0;
      type_nxt  = '0;
      size_nxt  = '0;
      time_nxt  = '0;
      nz_nxt    = 1'b0;
      acc_nxt   = '0;
      err_nxt   = ST_OK;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FILEHDR;
      cnt_r       <= '0;
      type_r      <= '0;
      size_r      <= '0;
      time_r      <= '0;
      nz_r        <= 1'b0;
      acc_r       <= '0;
      err_r       <= ST_OK;
      chk_hdr_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        type_r  <= type_nxt;
        size_r  <= size_nxt;
        time_r  <= time_nxt;
        nz_r    <= nz_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
      end
      if (cfg_wr_en) begin
        chk_hdr_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_type_r   <= res_type;
      out_size_r   <= res_size;
      out_time_r   <= res_time;
      out_status_r <= res_status;
      out_done_r   <= res_done;
    end
  end

  `FLV_TSP_ASSERT_NOW(a_last_gives_result, clk, rst_n, fire && q_beat.last, emit)
  `FLV_TSP_ASSERT_NEXT(a_last_resets, clk, rst_n, fire && q_beat.last,
    (phase_r == PH_FILEHDR) && (cnt_r == 24'd0) && (err_r == ST_OK))
  `FLV_TSP_ASSERT_NOW(a_filehdr_cnt, clk, rst_n, phase_r == PH_FILEHDR, cnt_r < FILE_HDR_LEN)
  `FLV_TSP_ASSERT_NOW(a_taghdr_cnt, clk, rst_n, phase_r == PH_TAGHDR, cnt_r < TAG_HDR_LEN)

endmodule

`default_nettype wire

>>> dv/flv_tag_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_stream_checker
// Shared FLV constants, plus a checker that follows every accepted byte beat
// with its own parser model and compares each result beat, field by field,
// with the oldest result it expects.
// ----------------------------------------------------------------------------

package flv_tsp_tb_pkg;

  localparam int FILE_HDR_LEN = 13;
  localparam int TAG_HDR_LEN  = 11;

  localparam logic [8*FILE_HDR_LEN-1:0] FLV_MAGIC =
    104'h46_4C_56_01_05_00_00_00_09_00_00_00_00;

  localparam logic [7:0] TAG_AUDIO  = 8'h08;
  localparam logic [7:0] TAG_VIDEO  = 8'h09;
  localparam logic [7:0] TAG_SCRIPT = 8'h12;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_HEADER     = 3'd1,
    ST_BAD_TYPE       = 3'd2,
    ST_NONZERO_STREAM = 3'd3,
    ST_SIZE_MISMATCH  = 3'd4,
    ST_TRUNCATED      = 3'd5
  } flv_status_e;

  typedef struct packed {
    logic [7:0]  tag_type;
    logic [23:0] payload_size;
    logic [31:0] timestamp;
    flv_status_e status;
    logic        done;
  } tag_result_t;

  function automatic logic [7:0] flv_magic_byte(input int idx);
    return FLV_MAGIC[8*(FILE_HDR_LEN-1-idx) +: 8];
  endfunction

endpackage

module flv_tag_stream_checker
  import flv_tsp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_tag_type,
  input  logic [23:0] out_payload_size,
  input  logic [31:0] out_timestamp,
  input  logic [2:0]  out_status,
  input  logic        out_stream_done,
  output int          fail_count,
  output int          pending_results
);

  typedef enum logic [2:0] {
    PH_FILE_HDR,
    PH_TAG_HDR,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_ERROR
  } parse_phase_e;

  logic         hdr_check;
  parse_phase_e phase;
  logic [23:0]  byte_cnt;
  logic [7:0]   tag_type;
  logic [23:0]  tag_size;
  logic [31:0]  tag_time;
  logic         id_nonzero;
  logic [31:0]  trailer_word;
  flv_status_e  err_code;
  tag_result_t  expected_q[$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void open_tag();
    phase        = PH_TAG_HDR;
    byte_cnt     = '0;
    tag_type     = '0;
    tag_size     = '0;
    tag_time     = '0;
    id_nonzero   = 1'b0;
    trailer_word = '0;
  endfunction

  function automatic void clear_parser();
    open_tag();
    phase    = PH_FILE_HDR;
    err_code = ST_OK;
  endfunction

  function automatic tag_result_t held_fields(input flv_status_e st, input logic done);
    tag_result_t r;
    r.tag_type     = tag_type;
    r.payload_size = tag_size;
    r.timestamp    = tag_time;
    r.status       = st;
    r.done         = done;
    return r;
  endfunction

  // one byte through the parser; returns 1 when it yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output tag_result_t r);
    bit          fault;
    flv_status_e st;
    fault = 1'b0;
    st    = ST_OK;
    r     = '0;
    case (phase)
      PH_FILE_HDR: begin
        if (hdr_check && b != flv_magic_byte(int'(byte_cnt))) begin
          st    = ST_BAD_HEADER;
          fault = 1'b1;
        end else begin
          byte_cnt = byte_cnt + 1'b1;
          if (byte_cnt >= FILE_HDR_LEN) open_tag();
        end
      end
      PH_TAG_HDR: begin
        if (byte_cnt == 0) begin
          tag_type = b;
          if (b != TAG_AUDIO && b != TAG_VIDEO && b != TAG_SCRIPT) begin
            st    = ST_BAD_TYPE;
            fault = 1'b1;
          end
        end else if (byte_cnt <= 3) begin
          tag_size = {tag_size[15:0], b};
        end else if (byte_cnt <= 6) begin
          tag_time = {8'h00, tag_time[15:0], b};
        end else if (byte_cnt == 7) begin
          tag_time[31:24] = b;  // extension byte
        end else if (b != 8'h00) begin
          id_nonzero = 1'b1;
        end
        if (!fault) begin
          byte_cnt = byte_cnt + 1'b1;
          if (byte_cnt >= TAG_HDR_LEN) begin
            if (id_nonzero) begin
              st    = ST_NONZERO_STREAM;
              fault = 1'b1;
            end else begin
              byte_cnt = '0;
              phase    = (tag_size == 0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= tag_size) begin
          byte_cnt = '0;
          phase    = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        trailer_word = {trailer_word[23:0], b};
        byte_cnt     = byte_cnt + 1'b1;
        if (byte_cnt >= 4) begin
          st = (trailer_word == 32'(tag_size) + 32'(TAG_HDR_LEN)) ? ST_OK : ST_SIZE_MISMATCH;
          r  = held_fields(st, last);
          if (st != ST_OK) begin
            err_code = st;
            phase    = PH_ERROR;
          end else begin
            open_tag();
          end
          if (last) clear_parser();
          return 1'b1;
        end
      end
      default: ;
    endcase

    if (fault) begin
      err_code = st;
      phase    = PH_ERROR;
      r        = held_fields(st, last);
      if (last) clear_parser();
      return 1'b1;
    end

    if (last) begin
      // clean end only on a tag boundary; the error phase repeats its code
      if (phase == PH_ERROR) st = err_code;
      else if (phase == PH_TAG_HDR && byte_cnt == 0) st = ST_OK;
      else st = ST_TRUNCATED;
      r = held_fields(st, 1'b1);
      clear_parser();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    tag_result_t want;
    if (!rst_n) begin
      hdr_check = 1'b1;
      clear_parser();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected (status %0d)",
                                    out_status));
        end else begin
          want = expected_q.pop_front();
          if (out_tag_type !== want.tag_type)
            report_mismatch($sformatf("tag_type: got %0h, expected %0h",
                                      out_tag_type, want.tag_type));
          if (out_payload_size !== want.payload_size)
            report_mismatch($sformatf("payload_size: got %0h, expected %0h",
                                      out_payload_size, want.payload_size));
          if (out_timestamp !== want.timestamp)
            report_mismatch($sformatf("timestamp: got %0h, expected %0h",
                                      out_timestamp, want.timestamp));
          if (out_status !== want.status)
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      out_status, want.status));
          if (out_stream_done !== want.done)
            report_mismatch($sformatf("stream_done: got %0b, expected %0b",
                                      out_stream_done, want.done));
        end
      end
      if (cfg_wr_en) hdr_check = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (parse_byte(in_data_byte, in_last_byte, want)) expected_q.push_back(want);
      end
    end
    pending_results = expected_q.size();
  end

endmodule

>>> dv/flv_tag_stream_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_core_tb
// Feeds the FLV parser with short directed streams, then random streams that
// are mostly well formed (good header, tags with correct trailers) with
// corrupted headers, bad types, nonzero stream ids, wrong trailers and early
// ends mixed in. Header checking is switched between phases; both sides idle
// at random outside phase 2, and the result side holds off once long enough to back up input.
// ----------------------------------------------------------------------------

module flv_tag_stream_parser_core_tb;
  import flv_tsp_tb_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int ITEMS         = 650;
  localparam int NUM_PHASES    = 4;
  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_wr_en    = 1'b0;
  logic        cfg_wr_data  = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_tag_type;
  logic [23:0] out_payload_size;
  logic [31:0] out_timestamp;
  logic [2:0]  out_status;
  logic        out_stream_done;

  int fail_count;
  int pending_results;
  int items_sent   = 0;
  int cycle_cnt    = 0;

  bit         gaps_on   = 1'b1;
  bit         hold_req  = 1'b0;
  bit         hold_used = 1'b0;
  bit         hdr_check_now = 1'b1;
  bit         stream_broken;
  logic [7:0] stream_bytes[$];

  flv_tag_stream_parser_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tag_type     (out_tag_type),
    .out_payload_size (out_payload_size),
    .out_timestamp    (out_timestamp),
    .out_status       (out_status),
    .out_stream_done  (out_stream_done)
  );

  flv_tag_stream_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tag_type     (out_tag_type),
    .out_payload_size (out_payload_size),
    .out_timestamp    (out_timestamp),
    .out_status       (out_status),
    .out_stream_done  (out_stream_done),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin : reset_seq
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // pending is read away from the sampling edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_header_check(input logic v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_tag();
    logic [7:0]  ttype;
    logic [23:0] size;
    logic [31:0] stamp;
    logic [31:0] trailer;
    int          pick;
    case ($urandom_range(2))
      0:       ttype = TAG_AUDIO;
      1:       ttype = TAG_VIDEO;
      default: ttype = TAG_SCRIPT;
    endcase
    if ($urandom_range(99) < 8) ttype = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 60)      size = 24'($urandom_range(6));
    else if (pick < 90) size = 24'($urandom_range(24, 7));
    else if (pick < 97) size = 24'($urandom_range(80, 25));
    else if (pick < 99) size = 24'($urandom());
    else                size = '1;
    stamp = ($urandom_range(9) == 0) ? '1 : $urandom();

    stream_bytes.push_back(ttype);
    stream_bytes.push_back(size[23:16]);
    stream_bytes.push_back(size[15:8]);
    stream_bytes.push_back(size[7:0]);
    stream_bytes.push_back(stamp[23:16]);
    stream_bytes.push_back(stamp[15:8]);
    stream_bytes.push_back(stamp[7:0]);
    stream_bytes.push_back(stamp[31:24]);
    pick = ($urandom_range(99) < 8) ? $urandom_range(2) : -1;
    for (int k = 0; k < 3; k++)
      stream_bytes.push_back((k == pick) ? 8'($urandom_range(255, 1)) : 8'h00);

    if ((ttype != TAG_AUDIO && ttype != TAG_VIDEO && ttype != TAG_SCRIPT) || pick >= 0) begin
      stream_broken = 1'b1;
      return;
    end
    // huge payloads are never sent whole: the stream ends inside them
    if (size > 80) begin
      repeat ($urandom_range(8)) stream_bytes.push_back(8'($urandom()));
      stream_broken = 1'b1;
      return;
    end
    repeat (size) stream_bytes.push_back(8'($urandom()));

    trailer = 32'(size) + 32'(TAG_HDR_LEN);
    if ($urandom_range(99) < 10) begin
      trailer       = trailer ^ (32'd1 << $urandom_range(31));
      stream_broken = 1'b1;
    end
    stream_bytes.push_back(trailer[31:24]);
    stream_bytes.push_back(trailer[23:16]);
    stream_bytes.push_back(trailer[15:8]);
    stream_bytes.push_back(trailer[7:0]);
  endtask

  task automatic build_stream();
    int ntags;
    int pos;
    stream_bytes.delete();
    stream_broken = 1'b0;
    for (int k = 0; k < FILE_HDR_LEN; k++) stream_bytes.push_back(flv_magic_byte(k));
    if (!hdr_check_now && $urandom_range(99) < 25) begin
      for (int k = 0; k < FILE_HDR_LEN; k++) stream_bytes[k] = 8'($urandom());
    end else if ($urandom_range(99) < 10) begin
      pos               = $urandom_range(FILE_HDR_LEN - 1);
      stream_bytes[pos] = stream_bytes[pos] ^ 8'($urandom_range(255, 1));
      stream_broken     = hdr_check_now;
    end
    ntags = $urandom_range(4);
    for (int k = 0; k < ntags && !stream_broken; k++) add_tag();
    // a few bytes after the break: in the error phase, or inside a cut-off payload
    if (stream_broken) repeat ($urandom_range(3)) stream_bytes.push_back(8'($urandom()));
  endtask

  task automatic send_stream();
    int stop;
    stop = stream_bytes.size() - 1;
    if (!stream_broken && $urandom_range(99) < 15) stop = $urandom_range(stop);
    for (int k = 0; k <= stop; k++) send_byte(stream_bytes[k], k == stop);
  endtask

  initial begin : stimulus
    @(posedge rst_n);
    set_header_check(1'b1);

    send_byte(8'h00, 1'b1);         // wrong first byte on a one-byte stream
    send_byte(8'h46, 1'b0);
    send_byte(8'h4C, 1'b0);
    send_byte(8'hFF, 1'b0);         // header mismatch mid-header
    send_byte(8'hFF, 1'b1);         // end while in the error phase
    send_byte(8'h46, 1'b1);         // stream cut inside the header
    for (int k = 0; k < FILE_HDR_LEN; k++) send_byte(flv_magic_byte(k), 1'b0);
    send_byte(8'hFF, 1'b0);         // bad tag type
    send_byte(8'h00, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      hdr_check_now = (p == NUM_PHASES - 1) ? 1'($urandom_range(1)) : ((p % 2) == 0);
      set_header_check(hdr_check_now);
      gaps_on = (p != 2);
      while (items_sent < ITEMS * (p + 1) / NUM_PHASES) begin
        if (p == 1 && !hold_used) begin
          hold_req  = 1'b1;
          hold_used = 1'b1;
        end
        build_stream();
        send_stream();
      end
    end

    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> flv_tag_stream_parser_core.f
+incdir+src
src/flv_tsp_pkg.sv
src/flv_tsp_front.sv
src/flv_tsp_queue.sv
src/flv_tsp_parse.sv
src/flv_tag_stream_parser_core.sv
dv/flv_tag_stream_checker.sv
dv/flv_tag_stream_parser_core_tb.sv
